// File: rtl/core/assert_macros.svh
// Assertion macros shared by the walk detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/ftwd_pkg.sv
// Types, constants and helpers shared by the walk detector RTL.
package ftwd_pkg;

    localparam int POS_W      = 32;
    localparam int JUMP_MAX   = 19660;
    localparam int RADIAL_MIN = 1966;
    localparam int IDLE_LIMIT = 450;
    localparam int IDLE_SAT   = 511;
    localparam int STRIDE_MIN = 16384;
    localparam int RETURN_MIN = 13107;
    localparam int PERCENT    = 100;

    localparam int MUL_W   = 33;
    localparam int SQRT_N  = 32;
    localparam int DIV_W   = 43;
    localparam int DEN_W   = 23;
    localparam int RES_W   = 66;
    localparam int CNT_W   = 6;

    localparam logic [1:0] CFG_MOVE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ALLOW_BACK = 2'd1;
    localparam logic [1:0] CFG_SMOOTH     = 2'd2;
    localparam logic [1:0] CFG_SPEED      = 2'd3;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } t_su_op;

    typedef struct packed {
        logic           start;
        t_su_op         op;
        logic [63:0]    opa;
        logic [MUL_W-1:0] opb;
    } t_su_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [RES_W-1:0] result;
    } t_su_stat;

    typedef enum logic [1:0] {
        WALK_STILL = 2'd0,
        WALK_FWD   = 2'd1,
        WALK_BACK  = 2'd2
    } t_walk;

    typedef enum logic [1:0] {
        HS_STEP = 2'd0,
        HS_NOW  = 2'd1,
        HS_PREV = 2'd2
    } t_hsel;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIFF, ST_MAG, ST_SQA_GO, ST_SQA_WT, ST_SQB_GO, ST_SQB_WT,
        ST_RT_GO, ST_RT_WT, ST_JUMP, ST_PDIS, ST_RAD, ST_WALK, ST_STROKE,
        ST_STEP, ST_RET, ST_MUL_GO, ST_MUL_WT, ST_DIV_GO, ST_DIV_WT, ST_ADD,
        ST_DONE
    } t_state;

    function automatic logic signed [31:0] f_sat_s32(input logic signed [45:0] v);
        logic signed [45:0] hi;
        logic signed [45:0] lo;
        hi = 46'sd2147483647;
        lo = -46'sd2147483648;
        if (v > hi) return 32'sh7FFFFFFF;
        else if (v < lo) return 32'sh80000000;
        else return $signed(v[31:0]);
    endfunction

    function automatic logic [31:0] f_sat_u32(input logic [35:0] v);
        if (v[35:32] != 4'd0) return 32'hFFFFFFFF;
        else return v[31:0];
    endfunction

endpackage

// File: rtl/core/ftwd_serial_unit.sv
// Shared bit-serial multiply, square root and divide unit.
`include "assert_macros.svh"

module ftwd_serial_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ftwd_pkg::t_su_cmd  i_cmd,
    output ftwd_pkg::t_su_stat o_stat
);

    logic                          r_busy;
    logic                          r_done;
    ftwd_pkg::t_su_op              r_op;
    logic [ftwd_pkg::CNT_W-1:0]    r_cnt;
    logic [ftwd_pkg::RES_W-1:0]    r_acc;
    logic [ftwd_pkg::MUL_W-1:0]    r_mcand;
    logic [35:0]                   r_rem;
    logic [ftwd_pkg::DIV_W-1:0]    r_res;

    logic [33:0] w_msum;
    logic [35:0] w_rs;
    logic [35:0] w_trial;
    logic [23:0] w_rd;
    logic [23:0] w_dv;

    assign w_msum  = {1'b0, r_acc[65:33]} + (r_acc[0] ? {1'b0, r_mcand} : 34'd0);
    assign w_rs    = {r_rem[33:0], r_acc[63:62]};
    assign w_trial = {2'b00, r_res[31:0], 2'b01};
    assign w_rd    = {r_rem[22:0], r_acc[42]};
    assign w_dv    = {1'b0, r_mcand[22:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= ftwd_pkg::OP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_rem  <= '0;
                r_res  <= '0;
                case (i_cmd.op)
                    ftwd_pkg::OP_MUL: begin
                        r_cnt   <= 6'(ftwd_pkg::MUL_W);
                        r_acc   <= {33'd0, i_cmd.opb};
                        r_mcand <= i_cmd.opa[32:0];
                    end
                    ftwd_pkg::OP_SQRT: begin
                        r_cnt   <= 6'(ftwd_pkg::SQRT_N);
                        r_acc   <= {2'b00, i_cmd.opa};
                        r_mcand <= '0;
                    end
                    default: begin
                        r_cnt   <= 6'(ftwd_pkg::DIV_W);
                        r_acc   <= {23'd0, i_cmd.opa[42:0]};
                        r_mcand <= {10'd0, i_cmd.opb[22:0]};
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    ftwd_pkg::OP_MUL: begin
                        r_acc <= {w_msum, r_acc[32:1]};
                    end
                    ftwd_pkg::OP_SQRT: begin
                        r_acc <= r_acc << 2;
                        if (w_rs >= w_trial) begin
                            r_rem <= w_rs - w_trial;
                            r_res <= {r_res[41:0], 1'b1};
                        end else begin
                            r_rem <= w_rs;
                            r_res <= {r_res[41:0], 1'b0};
                        end
                    end
                    default: begin
                        r_acc <= r_acc << 1;
                        if (w_rd >= w_dv) begin
                            r_rem <= 36'(w_rd - w_dv);
                            r_res <= {r_res[41:0], 1'b1};
                        end else begin
                            r_rem <= 36'(w_rd);
                            r_res <= {r_res[41:0], 1'b0};
                        end
                    end
                endcase
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy   = r_busy;
    assign o_stat.done   = r_done;
    assign o_stat.result = (r_op == ftwd_pkg::OP_MUL) ? r_acc : {23'd0, r_res};

    `ASSERT_IMP(a_done_excl, i_clk, i_rst_n, r_done, !r_busy)
    `ASSERT_NEXT(a_no_spont, i_clk, i_rst_n, (!r_busy && !i_cmd.start), !r_busy)
    `ASSERT_IMP(a_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != 6'd0)

endmodule

// File: rtl/core/foot_tracker_walk_detector.sv
// Walk-in-place detector: sequencer, per-foot state and result register.
// Each sample transaction carries one foot position and a reference centre in signed
// Q16.16 metres; exactly one result transaction follows it, holding the play-area
// offset, the walk direction, the step count and the walked distance. Samples are
// handled one at a time. All arithmetic goes through one shared bit-serial unit
// (one product bit, one root bit or one quotient bit per cycle): each of the three
// distances takes two squarings and a root, and each of the two scaled offset
// updates (one per axis) a multiply and a divide. A sample whose jump exceeds
// 0.3 m ends after the first distance, a stroke that moves the offset runs all
// of these steps, and others the three distances only. The sample port is ready
// whenever no sample is in progress; a finished result waits in the output
// register while the next sample is taken.
// Configuration writes are always accepted and must only arrive while idle.
`include "assert_macros.svh"

module foot_tracker_walk_detector (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // sample stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // pos_x, pos_z, centre_x, centre_z
    input  logic         i_s_tuser,   // foot_id
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,   // offset_x_out, offset_z_out, offset_moved,
                                      // walk_dir, step_total, distance_total, zero pad
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_addr,
    input  logic [16:0]  i_cfg_data
);

    // configuration
    logic [16:0] r_cfg_limit;
    logic        r_cfg_back;
    logic        r_cfg_smooth;
    logic [9:0]  r_cfg_speed;

    // sequencer
    ftwd_pkg::t_state n_state;
    ftwd_pkg::t_state r_state;
    ftwd_pkg::t_hsel  r_hsel;
    logic             r_axis;

    // sample under way
    logic               r_foot;
    logic signed [31:0] r_px, r_pz, r_cx, r_cz;

    // working registers
    logic signed [32:0] r_vx, r_vz, r_dx, r_dz;
    logic [30:0]        r_a, r_b;
    logic [1:0]         r_sh;
    logic [62:0]        r_sum;
    logic [33:0]        r_cha, r_hnow, r_hprev;
    logic signed [34:0] r_pdis;
    logic               r_moved;
    logic               r_neg;
    logic [42:0]        r_prod;
    logic signed [43:0] r_mval;
    logic               r_moved_out;

    // per-foot state
    logic signed [31:0] r_prev_x [2];
    logic signed [31:0] r_prev_z [2];
    logic [31:0]        r_jump   [2];
    logic signed [31:0] r_radial [2];
    logic [8:0]         r_idle   [2];
    ftwd_pkg::t_walk    r_fdir   [2];
    logic signed [31:0] r_sumx   [2];
    logic signed [31:0] r_sumz   [2];
    logic [15:0]        r_count  [2];
    logic               r_armed  [2];
    logic signed [31:0] r_stride [2];
    logic [31:0]        r_ret    [2];
    logic               r_adv    [2];

    // shared state
    ftwd_pkg::t_walk    r_walk;
    logic [23:0]        r_step;
    logic [31:0]        r_dist;
    logic signed [31:0] r_offx, r_offz;

    // result register
    logic               r_mvalid;
    logic signed [31:0] r_m_offx, r_m_offz;
    logic               r_m_moved;
    ftwd_pkg::t_walk    r_m_walk;
    logic [23:0]        r_m_step;
    logic [31:0]        r_m_dist;

    ftwd_pkg::t_su_cmd  su_cmd;
    ftwd_pkg::t_su_stat w_stat;

    ftwd_serial_unit u_su (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (su_cmd),
        .o_stat  (w_stat)
    );

    logic               w_f, w_o;
    logic signed [32:0] w_ax, w_bx, w_az, w_bz, w_vx, w_vz;
    logic [32:0]        w_ma, w_mb, w_or, w_sra, w_srb;
    logic [1:0]         w_sh;
    logic [33:0]        w_root;
    logic signed [31:0] w_rad;
    logic               w_go;
    logic [8:0]         w_idle_nx;
    ftwd_pkg::t_walk    w_walk_nx;
    logic               w_fwd, w_block, w_stride_big;
    logic signed [32:0] w_num;
    logic [32:0]        w_num_mag;
    logic [22:0]        w_cnt_ext, w_den;
    logic [42:0]        w_q;

    assign w_f = r_foot;
    assign w_o = ~r_foot;

    // operand selection for the three distances
    always_comb begin
        case (r_hsel)
            ftwd_pkg::HS_NOW: begin
                w_ax = 33'(r_px);
                w_bx = 33'(r_cx);
                w_az = 33'(r_pz);
                w_bz = 33'(r_cz);
            end
            ftwd_pkg::HS_PREV: begin
                w_ax = 33'(r_prev_x[w_f]);
                w_bx = 33'(r_cx);
                w_az = 33'(r_prev_z[w_f]);
                w_bz = 33'(r_cz);
            end
            default: begin
                w_ax = 33'(r_px);
                w_bx = 33'(r_prev_x[w_f]);
                w_az = 33'(r_pz);
                w_bz = 33'(r_prev_z[w_f]);
            end
        endcase
    end

    assign w_vx  = w_ax - w_bx;
    assign w_vz  = w_az - w_bz;
    assign w_ma  = r_vx[32] ? 33'(-r_vx) : 33'(r_vx);
    assign w_mb  = r_vz[32] ? 33'(-r_vz) : 33'(r_vz);
    assign w_or  = w_ma | w_mb;
    // halve both until each magnitude fits in 31 bits
    assign w_sh  = w_or[32] ? 2'd2 : (w_or[31] ? 2'd1 : 2'd0);
    assign w_sra = w_ma >> w_sh;
    assign w_srb = w_mb >> w_sh;
    assign w_root = {2'b00, w_stat.result[31:0]} << r_sh;

    // radial swing and idle decision
    assign w_rad = r_radial[w_f];
    assign w_go  = ((w_rad > ftwd_pkg::RADIAL_MIN) || (w_rad < -ftwd_pkg::RADIAL_MIN))
                   && r_moved;
    assign w_idle_nx = (r_idle[w_f] < 9'(ftwd_pkg::IDLE_SAT)) ? r_idle[w_f] + 9'd1
                                                              : r_idle[w_f];
    always_comb begin
        w_walk_nx = r_walk;
        if (w_go) begin
            if (r_walk == ftwd_pkg::WALK_STILL) begin
                w_walk_nx = (r_cfg_back && (r_pdis < 0)) ? ftwd_pkg::WALK_BACK
                                                         : ftwd_pkg::WALK_FWD;
            end
        end else if ((w_idle_nx > 9'(ftwd_pkg::IDLE_LIMIT))
                     && (r_walk != ftwd_pkg::WALK_STILL)
                     && (r_fdir[w_o] == ftwd_pkg::WALK_STILL)) begin
            w_walk_nx = ftwd_pkg::WALK_STILL;
        end
    end

    // stroke classification: a stroke along the walk direction advances
    assign w_fwd   = (r_pdis < 0) == (r_walk == ftwd_pkg::WALK_FWD);
    assign w_block = (r_cha < {2'b00, r_jump[w_o]}) && r_adv[w_o];
    assign w_stride_big = (r_stride[w_f] > ftwd_pkg::STRIDE_MIN)
                          || (r_stride[w_f] < -ftwd_pkg::STRIDE_MIN);

    // offset step operands
    always_comb begin
        if (r_cfg_smooth) begin
            w_num = r_axis ? 33'(r_sumz[w_f]) : 33'(r_sumx[w_f]);
        end else begin
            w_num = r_axis ? r_dz : r_dx;
        end
    end
    assign w_num_mag = w_num[32] ? 33'(-w_num) : 33'(w_num);
    assign w_cnt_ext = 23'(r_count[w_f]);
    assign w_den = r_cfg_smooth ? (w_cnt_ext << 6) + (w_cnt_ext << 5) + (w_cnt_ext << 2)
                                : 23'(ftwd_pkg::PERCENT);
    assign w_q = w_stat.result[42:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ftwd_pkg::ST_IDLE:   if (i_s_tvalid) n_state = ftwd_pkg::ST_DIFF;
            ftwd_pkg::ST_DIFF:   n_state = ftwd_pkg::ST_MAG;
            ftwd_pkg::ST_MAG:    n_state = ftwd_pkg::ST_SQA_GO;
            ftwd_pkg::ST_SQA_GO: n_state = ftwd_pkg::ST_SQA_WT;
            ftwd_pkg::ST_SQA_WT: if (w_stat.done) n_state = ftwd_pkg::ST_SQB_GO;
            ftwd_pkg::ST_SQB_GO: n_state = ftwd_pkg::ST_SQB_WT;
            ftwd_pkg::ST_SQB_WT: if (w_stat.done) n_state = ftwd_pkg::ST_RT_GO;
            ftwd_pkg::ST_RT_GO:  n_state = ftwd_pkg::ST_RT_WT;
            ftwd_pkg::ST_RT_WT: begin
                if (w_stat.done) begin
                    case (r_hsel)
                        ftwd_pkg::HS_STEP: n_state = ftwd_pkg::ST_JUMP;
                        ftwd_pkg::HS_NOW:  n_state = ftwd_pkg::ST_DIFF;
                        default:           n_state = ftwd_pkg::ST_PDIS;
                    endcase
                end
            end
            ftwd_pkg::ST_JUMP: begin
                n_state = (r_cha > 34'(ftwd_pkg::JUMP_MAX)) ? ftwd_pkg::ST_DONE
                                                            : ftwd_pkg::ST_DIFF;
            end
            ftwd_pkg::ST_PDIS: n_state = ftwd_pkg::ST_RAD;
            ftwd_pkg::ST_RAD:  n_state = ftwd_pkg::ST_WALK;
            ftwd_pkg::ST_WALK: begin
                n_state = ((w_walk_nx == ftwd_pkg::WALK_STILL) || !r_moved)
                          ? ftwd_pkg::ST_DONE : ftwd_pkg::ST_STROKE;
            end
            ftwd_pkg::ST_STROKE: begin
                if (!w_fwd) n_state = ftwd_pkg::ST_RET;
                else if (w_block) n_state = ftwd_pkg::ST_DONE;
                else n_state = ftwd_pkg::ST_STEP;
            end
            ftwd_pkg::ST_STEP:   n_state = ftwd_pkg::ST_MUL_GO;
            ftwd_pkg::ST_RET:    n_state = ftwd_pkg::ST_DONE;
            ftwd_pkg::ST_MUL_GO: n_state = ftwd_pkg::ST_MUL_WT;
            ftwd_pkg::ST_MUL_WT: if (w_stat.done) n_state = ftwd_pkg::ST_DIV_GO;
            ftwd_pkg::ST_DIV_GO: n_state = ftwd_pkg::ST_DIV_WT;
            ftwd_pkg::ST_DIV_WT: if (w_stat.done) n_state = ftwd_pkg::ST_ADD;
            ftwd_pkg::ST_ADD: begin
                n_state = r_axis ? ftwd_pkg::ST_DONE : ftwd_pkg::ST_MUL_GO;
            end
            ftwd_pkg::ST_DONE: begin
                if (!r_mvalid || i_m_tready) n_state = ftwd_pkg::ST_IDLE;
            end
            default: n_state = ftwd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: port ready and serial unit commands
    always_comb begin
        o_s_tready   = (r_state == ftwd_pkg::ST_IDLE);
        su_cmd.start = 1'b0;
        su_cmd.op    = ftwd_pkg::OP_MUL;
        su_cmd.opa   = '0;
        su_cmd.opb   = '0;
        case (r_state)
            ftwd_pkg::ST_SQA_GO: begin
                su_cmd.start = 1'b1;
                su_cmd.opa   = 64'(r_a);
                su_cmd.opb   = 33'(r_a);
            end
            ftwd_pkg::ST_SQB_GO: begin
                su_cmd.start = 1'b1;
                su_cmd.opa   = 64'(r_b);
                su_cmd.opb   = 33'(r_b);
            end
            ftwd_pkg::ST_RT_GO: begin
                su_cmd.start = 1'b1;
                su_cmd.op    = ftwd_pkg::OP_SQRT;
                su_cmd.opa   = {1'b0, r_sum};
            end
            ftwd_pkg::ST_MUL_GO: begin
                su_cmd.start = 1'b1;
                su_cmd.opa   = 64'(w_num_mag);
                su_cmd.opb   = 33'(r_cfg_speed);
            end
            ftwd_pkg::ST_DIV_GO: begin
                su_cmd.start = 1'b1;
                su_cmd.op    = ftwd_pkg::OP_DIV;
                su_cmd.opa   = 64'(r_prod);
                su_cmd.opb   = 33'(w_den);
            end
            default: begin
                su_cmd.start = 1'b0;
            end
        endcase
    end

    // configuration register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_limit  <= 17'd655;
            r_cfg_back   <= 1'b0;
            r_cfg_smooth <= 1'b0;
            r_cfg_speed  <= 10'd100;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                ftwd_pkg::CFG_MOVE_LIMIT: r_cfg_limit  <= i_cfg_data;
                ftwd_pkg::CFG_ALLOW_BACK: r_cfg_back   <= i_cfg_data[0];
                ftwd_pkg::CFG_SMOOTH:     r_cfg_smooth <= i_cfg_data[0];
                ftwd_pkg::CFG_SPEED:      r_cfg_speed  <= i_cfg_data[9:0];
                default:                  r_cfg_speed  <= r_cfg_speed;
            endcase
        end
    end

    // datapath and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftwd_pkg::ST_IDLE;
            r_hsel      <= ftwd_pkg::HS_STEP;
            r_axis      <= 1'b0;
            r_moved_out <= 1'b0;
            r_mvalid    <= 1'b0;
            r_walk      <= ftwd_pkg::WALK_STILL;
            r_step      <= '0;
            r_dist      <= '0;
            r_offx      <= '0;
            r_offz      <= '0;
            for (int i = 0; i < 2; i++) begin
                r_prev_x[i] <= '0;
                r_prev_z[i] <= '0;
                r_jump[i]   <= '0;
                r_radial[i] <= '0;
                r_idle[i]   <= '0;
                r_fdir[i]   <= ftwd_pkg::WALK_STILL;
                r_sumx[i]   <= '0;
                r_sumz[i]   <= '0;
                r_count[i]  <= '0;
                r_armed[i]  <= 1'b1;
                r_stride[i] <= '0;
                r_ret[i]    <= '0;
                r_adv[i]    <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            // drop the held result once taken, unless a new one replaces it
            if (r_mvalid && i_m_tready && (r_state != ftwd_pkg::ST_DONE)) r_mvalid <= 1'b0;
            case (r_state)
                ftwd_pkg::ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_foot      <= i_s_tuser;
                        r_px        <= $signed(i_s_tdata[31:0]);
                        r_pz        <= $signed(i_s_tdata[63:32]);
                        r_cx        <= $signed(i_s_tdata[95:64]);
                        r_cz        <= $signed(i_s_tdata[127:96]);
                        r_hsel      <= ftwd_pkg::HS_STEP;
                        r_axis      <= 1'b0;
                        r_moved_out <= 1'b0;
                    end
                end
                ftwd_pkg::ST_DIFF: begin
                    r_vx <= w_vx;
                    r_vz <= w_vz;
                    if (r_hsel == ftwd_pkg::HS_STEP) begin
                        r_dx <= w_vx;
                        r_dz <= w_vz;
                    end
                end
                ftwd_pkg::ST_MAG: begin
                    r_a  <= w_sra[30:0];
                    r_b  <= w_srb[30:0];
                    r_sh <= w_sh;
                end
                ftwd_pkg::ST_SQA_WT: if (w_stat.done) r_sum <= 63'(w_stat.result[61:0]);
                ftwd_pkg::ST_SQB_WT: begin
                    if (w_stat.done) r_sum <= r_sum + 63'(w_stat.result[61:0]);
                end
                ftwd_pkg::ST_RT_WT: begin
                    if (w_stat.done) begin
                        case (r_hsel)
                            ftwd_pkg::HS_STEP: r_cha <= w_root;
                            ftwd_pkg::HS_NOW: begin
                                r_hnow <= w_root;
                                r_hsel <= ftwd_pkg::HS_PREV;
                            end
                            default: r_hprev <= w_root;
                        endcase
                    end
                end
                ftwd_pkg::ST_JUMP: begin
                    r_adv[w_f]  <= 1'b0;
                    r_jump[w_f] <= ftwd_pkg::f_sat_u32(36'(r_cha));
                    r_hsel      <= ftwd_pkg::HS_NOW;
                end
                ftwd_pkg::ST_PDIS: begin
                    r_pdis <= $signed({1'b0, r_hnow}) - $signed({1'b0, r_hprev});
                end
                ftwd_pkg::ST_RAD: begin
                    r_radial[w_f] <= ftwd_pkg::f_sat_s32(46'(r_radial[w_f]) + 46'(r_pdis));
                    r_moved       <= r_cha > 34'({r_cfg_limit, 1'b0});
                end
                ftwd_pkg::ST_WALK: begin
                    r_walk <= w_walk_nx;
                    if (w_go) begin
                        r_radial[w_f] <= '0;
                        r_idle[w_f]   <= '0;
                    end else begin
                        r_idle[w_f] <= w_idle_nx;
                        if (w_idle_nx > 9'(ftwd_pkg::IDLE_LIMIT)) begin
                            r_fdir[w_f] <= ftwd_pkg::WALK_STILL;
                        end
                    end
                end
                ftwd_pkg::ST_STROKE: begin
                    r_fdir[w_f] <= r_walk;
                    if (w_fwd) begin
                        r_ret[w_f] <= '0;
                        if (!w_block) begin
                            if (r_armed[w_f]) begin
                                r_stride[w_f] <= ftwd_pkg::f_sat_s32(
                                    46'(r_stride[w_f]) + 46'(r_pdis));
                            end
                            r_dist     <= ftwd_pkg::f_sat_u32(36'(r_dist) + 36'(r_cha));
                            r_adv[w_f] <= 1'b1;
                            r_sumx[w_f] <= ftwd_pkg::f_sat_s32(46'(r_sumx[w_f]) + 46'(r_dx));
                            r_sumz[w_f] <= ftwd_pkg::f_sat_s32(46'(r_sumz[w_f]) + 46'(r_dz));
                            if (r_count[w_f] != 16'hFFFF) r_count[w_f] <= r_count[w_f] + 16'd1;
                        end
                    end else begin
                        r_ret[w_f] <= ftwd_pkg::f_sat_u32(36'(r_ret[w_f]) + 36'(r_cha));
                    end
                end
                ftwd_pkg::ST_STEP: begin
                    if (r_armed[w_f] && w_stride_big) begin
                        r_armed[w_f] <= 1'b0;
                        if (r_step != 24'hFFFFFF) r_step <= r_step + 24'd1;
                    end
                end
                ftwd_pkg::ST_RET: begin
                    // return stroke long enough: re-arm and restart the stroke mean
                    if (r_ret[w_f] > 32'(ftwd_pkg::RETURN_MIN)) begin
                        if (!r_armed[w_f]) begin
                            r_armed[w_f]  <= 1'b1;
                            r_stride[w_f] <= '0;
                        end
                        r_count[w_f] <= '0;
                        r_sumx[w_f]  <= '0;
                        r_sumz[w_f]  <= '0;
                    end
                end
                ftwd_pkg::ST_MUL_GO: r_neg <= w_num[32];
                ftwd_pkg::ST_MUL_WT: if (w_stat.done) r_prod <= w_stat.result[42:0];
                ftwd_pkg::ST_DIV_WT: begin
                    if (w_stat.done) begin
                        r_mval <= r_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
                    end
                end
                ftwd_pkg::ST_ADD: begin
                    if (r_axis) begin
                        r_offz      <= ftwd_pkg::f_sat_s32(46'(r_offz) + 46'(r_mval));
                        r_moved_out <= 1'b1;
                    end else begin
                        r_offx <= ftwd_pkg::f_sat_s32(46'(r_offx) + 46'(r_mval));
                        r_axis <= 1'b1;
                    end
                end
                ftwd_pkg::ST_DONE: begin
                    r_prev_x[w_f] <= r_px;
                    r_prev_z[w_f] <= r_pz;
                    if (!r_mvalid || i_m_tready) begin
                        r_mvalid  <= 1'b1;
                        r_m_offx  <= r_offx;
                        r_m_offz  <= r_offz;
                        r_m_moved <= r_moved_out;
                        r_m_walk  <= r_walk;
                        r_m_step  <= r_step;
                        r_m_dist  <= r_dist;
                    end
                end
                default: begin
                    r_axis <= r_axis;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = {5'd0, r_m_dist, r_m_step, r_m_walk, r_m_moved, r_m_offz, r_m_offx};

    `ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_stat.done, (r_state == ftwd_pkg::ST_SQA_WT || r_state == ftwd_pkg::ST_SQB_WT || r_state == ftwd_pkg::ST_RT_WT || r_state == ftwd_pkg::ST_MUL_WT || r_state == ftwd_pkg::ST_DIV_WT))
    `ASSERT_IMP(a_start_free, i_clk, i_rst_n, su_cmd.start, !w_stat.busy)
    `ASSERT_IMP(a_moved_walks, i_clk, i_rst_n, (r_mvalid && r_m_moved), (r_m_walk != ftwd_pkg::WALK_STILL))

endmodule

// File: sim/tb_foot_tracker_walk_detector.sv
// Self-checking testbench for the foot tracker walk detector.
module tb_foot_tracker_walk_detector;
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: mirrors the detector state and holds the results still to come.
    class walk_scoreboard;
        typedef struct packed {
            logic [31:0] off_x;
            logic [31:0] off_z;
            logic        moved;
            logic [1:0]  dir;
            logic [23:0] steps;
            logic [31:0] travel;
        } walk_result_t;

        walk_result_t due_q[$];
        int           errors;

        // configuration copy
        logic [16:0] lim;
        bit          back_en;
        bit          smooth_en;
        logic [9:0]  speed;

        // per-foot state
        longint      last_x[2], last_z[2], rad_sum[2], stride_sum[2];
        longint      sum_x[2], sum_z[2];
        logic [31:0] jump_len[2], ret_len[2];
        int          idle_n[2], stroke_n[2];
        ftwd_pkg::t_walk fdir[2];
        bit          armed[2], advanced[2];

        // shared state
        ftwd_pkg::t_walk walk;
        logic [23:0] step_cnt;
        logic [31:0] dist_acc;
        longint      off_x, off_z;

        function new();
            lim = 17'd655;
            back_en = 0;
            smooth_en = 0;
            speed = 10'd100;
            for (int f = 0; f < 2; f++) begin
                last_x[f] = 0; last_z[f] = 0; rad_sum[f] = 0; stride_sum[f] = 0;
                sum_x[f] = 0; sum_z[f] = 0; jump_len[f] = 0; ret_len[f] = 0;
                idle_n[f] = 0; stroke_n[f] = 0; fdir[f] = ftwd_pkg::WALK_STILL;
                armed[f] = 1; advanced[f] = 0;
            end
            walk = ftwd_pkg::WALK_STILL;
            step_cnt = 0;
            dist_acc = 0;
            off_x = 0;
            off_z = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            case (idx)
                ftwd_pkg::CFG_MOVE_LIMIT: lim = val;
                ftwd_pkg::CFG_ALLOW_BACK: back_en = val[0];
                ftwd_pkg::CFG_SMOOTH:     smooth_en = val[0];
                ftwd_pkg::CFG_SPEED:      speed = val[9:0];
                default: ;
            endcase
        endfunction

        function longint unsigned magnitude(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Euclidean length, halving large components to keep the squares in range
        function longint unsigned span(longint dx, longint dz);
            longint unsigned a;
            longint unsigned b;
            int sh;
            a = magnitude(dx);
            b = magnitude(dz);
            sh = 0;
            while (a >= 64'h8000_0000 || b >= 64'h8000_0000) begin
                a >>= 1;
                b >>= 1;
                sh++;
            end
            return int_root(a * a + b * b) << sh;
        endfunction

        function longint clamp_s32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic [31:0] clamp_u32(longint unsigned v);
            return v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        // Advance the mirrored state by one accepted sample and queue its result.
        function void note_sample(bit f, logic [31:0] x, logic [31:0] z,
                                  logic [31:0] cx, logic [31:0] cz);
            int o;
            longint px, pz, dx, dz, pdis, mx, mz, den;
            longint unsigned cha;
            bit moved, moved_out;
            walk_result_t r;
            o = 1 - f;
            px = longint'($signed(x));
            pz = longint'($signed(z));
            dx = px - last_x[f];
            dz = pz - last_z[f];
            cha = span(dx, dz);
            moved_out = 0;
            advanced[f] = 0;
            jump_len[f] = clamp_u32(cha);
            if (cha <= ftwd_pkg::JUMP_MAX) begin
                pdis = longint'(span(px - longint'($signed(cx)), pz - longint'($signed(cz))))
                     - longint'(span(last_x[f] - longint'($signed(cx)),
                                     last_z[f] - longint'($signed(cz))));
                rad_sum[f] = clamp_s32(rad_sum[f] + pdis);
                moved = cha > 2 * longint'(lim);
                if (magnitude(rad_sum[f]) > ftwd_pkg::RADIAL_MIN && moved) begin
                    rad_sum[f] = 0;
                    idle_n[f] = 0;
                    if (walk == ftwd_pkg::WALK_STILL)
                        walk = (back_en && pdis < 0) ? ftwd_pkg::WALK_BACK : ftwd_pkg::WALK_FWD;
                end else begin
                    if (idle_n[f] < ftwd_pkg::IDLE_SAT) idle_n[f]++;
                    if (idle_n[f] > ftwd_pkg::IDLE_LIMIT) begin
                        fdir[f] = ftwd_pkg::WALK_STILL;
                        if (walk != ftwd_pkg::WALK_STILL && fdir[0] == ftwd_pkg::WALK_STILL
                            && fdir[1] == ftwd_pkg::WALK_STILL)
                            walk = ftwd_pkg::WALK_STILL;
                    end
                end
                if (walk != ftwd_pkg::WALK_STILL && moved) begin
                    fdir[f] = walk;
                    if ((pdis < 0) == (walk == ftwd_pkg::WALK_FWD)) begin
                        ret_len[f] = 0;
                        // the other foot, still mid-stroke with a longer jump, blocks this one
                        if (!(cha < jump_len[o] && advanced[o])) begin
                            if (armed[f]) begin
                                stride_sum[f] = clamp_s32(stride_sum[f] + pdis);
                                if (magnitude(stride_sum[f]) > ftwd_pkg::STRIDE_MIN) begin
                                    armed[f] = 0;
                                    if (step_cnt != 24'hFF_FFFF) step_cnt++;
                                end
                            end
                            dist_acc = clamp_u32(longint'(dist_acc) + cha);
                            advanced[f] = 1;
                            sum_x[f] = clamp_s32(sum_x[f] + dx);
                            sum_z[f] = clamp_s32(sum_z[f] + dz);
                            if (stroke_n[f] < 65535) stroke_n[f]++;
                            if (smooth_en) begin
                                den = longint'(stroke_n[f]) * ftwd_pkg::PERCENT;
                                mx = sum_x[f] * longint'(speed) / den;
                                mz = sum_z[f] * longint'(speed) / den;
                            end else begin
                                mx = dx * longint'(speed) / ftwd_pkg::PERCENT;
                                mz = dz * longint'(speed) / ftwd_pkg::PERCENT;
                            end
                            off_x = clamp_s32(off_x + mx);
                            off_z = clamp_s32(off_z + mz);
                            moved_out = 1;
                        end
                    end else begin
                        ret_len[f] = clamp_u32(longint'(ret_len[f]) + cha);
                        if (ret_len[f] > ftwd_pkg::RETURN_MIN) begin
                            if (!armed[f]) begin
                                armed[f] = 1;
                                stride_sum[f] = 0;
                            end
                            stroke_n[f] = 0;
                            sum_x[f] = 0;
                            sum_z[f] = 0;
                        end
                    end
                end
            end
            last_x[f] = px;
            last_z[f] = pz;
            r.off_x = off_x[31:0];
            r.off_z = off_z[31:0];
            r.moved = moved_out;
            r.dir = walk;
            r.steps = step_cnt;
            r.travel = dist_acc;
            due_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [127:0] d);
            walk_result_t w;
            if (due_q.size() == 0) begin
                report("unexpected result", d[31:0], 0);
                return;
            end
            w = due_q.pop_front();
            if (d[31:0] !== w.off_x)   report("offset_x", d[31:0], w.off_x);
            if (d[63:32] !== w.off_z)  report("offset_z", d[63:32], w.off_z);
            if (d[64] !== w.moved)     report("offset_moved", d[64], w.moved);
            if (d[66:65] !== w.dir)    report("walk_dir", d[66:65], w.dir);
            if (d[90:67] !== w.steps)  report("step_total", d[90:67], w.steps);
            if (d[122:91] !== w.travel) report("distance_total", d[122:91], w.travel);
        endtask
    endclass

    localparam int STALL_LIMIT = 20000;  // cycles without any transaction
    localparam int DRAIN_WAIT  = 600;    // idle wait after the last result is back

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [127:0] i_s_tdata = '0;
    logic         i_s_tuser = 0;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [127:0] o_m_tdata;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_addr = '0;
    logic [16:0]  i_cfg_data = '0;

    walk_scoreboard sb = new();
    bit             steady = 0;  // no idling on either side while set
    int             quiet_cycles = 0;

    // stroke generator state: radius along a fixed bearing, and its direction
    longint walk_r[2];
    int     walk_sgn[2];

    foot_tracker_walk_detector uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: stall at random unless in the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 14);
        end
    end

    // Sample at the falling edge: values here are those the next rising edge will see.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Send one sample transaction, possibly after a short idle gap.
    task send_sample(bit f, logic [31:0] x, logic [31:0] z, logic [31:0] cx, logic [31:0] cz);
        bit took;
        if (!steady && $urandom_range(99) < 14) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= f;
        i_s_tdata <= {cz, cx, z, x};
        do begin
            @(negedge i_clk);
            took = o_s_tready;
            @(posedge i_clk);
        end while (!took);
        sb.note_sample(f, x, z, cx, cz);
    endtask

    // Hold one register write until it is taken; the caller drops valid afterwards.
    task write_reg(logic [1:0] idx, logic [16:0] val);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end while (!took);
        sb.set_reg(idx, val);
    endtask

    // Hold until every result is back, then write all four registers.
    task set_config(logic [16:0] limit, bit back, bit smooth, logic [9:0] spd);
        i_s_tvalid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        write_reg(ftwd_pkg::CFG_MOVE_LIMIT, limit);
        write_reg(ftwd_pkg::CFG_ALLOW_BACK, back);
        write_reg(ftwd_pkg::CFG_SMOOTH, smooth);
        write_reg(ftwd_pkg::CFG_SPEED, spd);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Walking in place: each foot swings in and out along a bearing from the centre,
    // feet alternating, with now and then a jump too long to be a stroke.
    task walk_strokes(int n);
        logic [31:0] cx, cz;
        longint      px, pz;
        int          f;
        cx = $urandom_range(131072) - 65536;
        cz = $urandom_range(131072) - 65536;
        for (int k = 0; k < n; k++) begin
            f = k % 2;
            if ($urandom_range(99) < 3) begin
                walk_r[f] += 30000;
            end else begin
                walk_r[f] += walk_sgn[f] * longint'($urandom_range(9000, 1200));
            end
            if (walk_r[f] > 36000) walk_sgn[f] = -1;
            if (walk_r[f] < 10000) walk_sgn[f] = 1;
            px = longint'($signed(cx)) + walk_r[f] + ($urandom_range(400) - 200);
            pz = longint'($signed(cz)) + (f ? walk_r[f] / 2 : -(walk_r[f] / 2));
            send_sample(f, px[31:0], pz[31:0], cx, cz);
        end
    endtask

    // Fully random samples: every bit of every field.
    task noise(int n);
        for (int k = 0; k < n; k++)
            send_sample($urandom_range(1), $urandom, $urandom, $urandom, $urandom);
    endtask

    // Feet standing still long enough for the idle count to stop walking.
    task stand_still(int n);
        for (int k = 0; k < n; k++)
            send_sample(k % 2, sb.last_x[k % 2][31:0], sb.last_z[k % 2][31:0], 0, 0);
    endtask

    initial begin
        walk_r[0] = 20000; walk_r[1] = 20000;
        walk_sgn[0] = 1; walk_sgn[1] = -1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of the fields, big jumps and small strokes
        send_sample(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(1, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        send_sample(0, 32'd4000, 32'd0, 32'd0, 32'd0);
        send_sample(1, 32'd4000, 32'd0, 32'd0, 32'd0);
        send_sample(0, 32'd9000, 32'd100, 32'd0, 32'd0);
        send_sample(1, 32'd15000, 32'd0, 32'd0, 32'd0);
        send_sample(0, 32'd4000, 32'd100, 32'd0, 32'd0);
        send_sample(0, 32'd4300, 32'd100, 32'd0, 32'd0);       // under the noise limit
        send_sample(1, 32'd19000, 32'hFFFF_F000, 32'd0, 32'd0);
        send_sample(0, 32'd23000, 32'd200, 32'd0, 32'd0);      // jump just under 0.3 m
        send_sample(0, 32'd43000, 32'd200, 32'd0, 32'd0);      // jump just over 0.3 m
        send_sample(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(1, 32'h7FFF_F000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);

        steady = 1;
        walk_strokes(100);
        steady = 0;
        noise(20);

        set_config(17'd0, 1'b1, 1'b1, 10'd1000);
        walk_strokes(80);
        stand_still(910);
        walk_strokes(40);

        set_config(17'd65536, 1'b0, 1'b1, 10'd0);
        walk_strokes(20);

        set_config(17'd100, 1'b1, 1'b0, 10'd1023);
        walk_strokes(40);
        noise(10);

        set_config(17'd1, 1'b0, 1'b1, 10'd37);
        walk_strokes(30);
        noise(10);

        // drain
        i_s_tvalid <= 1'b0;
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
